// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== hdl/obbot_pkg.sv =====
`default_nettype none
package obbot_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int NUM_SLOTS   = 15;
	localparam int MEM_DEPTH   = 2 * NUM_SLOTS;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int EPS_W       = 17;

	// Derived values (t, R, |R|+eps) need at most 67 bits.
	localparam int RW     = 2 * VALUE_WIDTH + 4;
	localparam int DIG_W  = 24;
	localparam int OP_W   = 3 * DIG_W;
	localparam int PP_W   = 2 * (DIG_W + 1);
	localparam int ACC_W  = 144;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef enum logic [2:0] {
		U_CLR, U_MAC, U_ADD, U_SHACC, U_LHS, U_CMP, U_STT, U_STR
	} uop_kind_t;

	typedef enum logic [2:0] {
		S_AE, S_BE, S_AU, S_BU, S_V, S_T, S_R, S_AR
	} src_t;

	typedef enum logic [2:0] {PH_T, PH_R, PH_A, PH_B, PH_X} phase_t;

	typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_RUN, ST_DONE} state_t;

	typedef struct packed {
		uop_kind_t   kind;
		src_t        a_src;
		logic [3:0]  a_idx;
		src_t        b_src;
		logic [3:0]  b_idx;
		logic        neg;
		logic [1:0]  sh;
		logic        last;
	} uop_t;

	typedef struct packed {
		logic       go;
		uop_kind_t  kind;
		logic       neg;
		logic [1:0] sh;
		logic [1:0] p;
		logic [1:0] q;
	} mac_ctl_t;

	function automatic logic [1:0] next3(input logic [1:0] x);
		return (x == 2'd2) ? 2'd0 : x + 2'd1;
	endfunction

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'({2'b00, r} * 4'd3) + 4'(c);
	endfunction

	// Microprogram: one step of the given phase and loop position.
	function automatic uop_t uop_at(input phase_t ph, input logic [1:0] i,
			input logic [1:0] j, input logic [3:0] st);
		uop_t u;
		logic [1:0] i1, i2, j1, j2, k1, k5, k6;
		u  = uop_t'('0);
		i1 = next3(i);
		i2 = next3(i1);
		j1 = next3(j);
		j2 = next3(j1);
		k1 = 2'(st - 4'd1);
		k5 = 2'(st - 4'd5);
		k6 = 2'(st - 4'd6);
		u.kind = U_CLR;
		case (ph)
			PH_T: begin
				case (st) inside
					4'd0: u.kind = U_CLR;
					[4'd1:4'd3]: begin
						u.kind = U_MAC; u.a_src = S_V; u.a_idx = 4'(k1);
						u.b_src = S_AU; u.b_idx = idx3(i, k1);
					end
					default: begin
						u.kind = U_STT; u.a_idx = 4'(i); u.last = 1'b1;
					end
				endcase
			end
			PH_R: begin
				case (st) inside
					4'd0: u.kind = U_CLR;
					[4'd1:4'd3]: begin
						u.kind = U_MAC; u.a_src = S_AU; u.a_idx = idx3(i, k1);
						u.b_src = S_BU; u.b_idx = idx3(j, k1);
					end
					default: begin
						u.kind = U_STR; u.a_idx = idx3(i, j); u.last = 1'b1;
					end
				endcase
			end
			PH_A: begin
				case (st) inside
					4'd0, 4'd3: u.kind = U_CLR;
					4'd1: begin
						u.kind = U_ADD; u.a_src = S_T; u.a_idx = 4'(i); u.sh = 2'd1;
					end
					4'd2: u.kind = U_LHS;
					4'd4: begin
						u.kind = U_ADD; u.a_src = S_AE; u.a_idx = 4'(i); u.sh = 2'd2;
					end
					[4'd5:4'd7]: begin
						u.kind = U_MAC; u.a_src = S_BE; u.a_idx = 4'(k5);
						u.b_src = S_AR; u.b_idx = idx3(i, k5);
					end
					default: begin
						u.kind = U_CMP; u.last = 1'b1;
					end
				endcase
			end
			PH_B: begin
				// The loop index i stands for the B axis here.
				case (st) inside
					4'd0, 4'd5: u.kind = U_CLR;
					[4'd1:4'd3]: begin
						u.kind = U_MAC; u.a_src = S_T; u.a_idx = 4'(k1);
						u.b_src = S_R; u.b_idx = idx3(k1, i);
					end
					4'd4: u.kind = U_LHS;
					[4'd6:4'd8]: begin
						u.kind = U_MAC; u.a_src = S_AE; u.a_idx = 4'(k6);
						u.b_src = S_AR; u.b_idx = idx3(k6, i);
					end
					4'd9: u.kind = U_SHACC;
					4'd10: begin
						u.kind = U_ADD; u.a_src = S_BE; u.a_idx = 4'(i); u.sh = 2'd3;
					end
					default: begin
						u.kind = U_CMP; u.last = 1'b1;
					end
				endcase
			end
			default: begin
				case (st) inside
					4'd0, 4'd4: u.kind = U_CLR;
					4'd1: begin
						u.kind = U_MAC; u.a_src = S_T; u.a_idx = 4'(i2);
						u.b_src = S_R; u.b_idx = idx3(i1, j);
					end
					4'd2: begin
						u.kind = U_MAC; u.a_src = S_T; u.a_idx = 4'(i1); u.neg = 1'b1;
						u.b_src = S_R; u.b_idx = idx3(i2, j);
					end
					4'd3: u.kind = U_LHS;
					4'd5: begin
						u.kind = U_MAC; u.a_src = S_AE; u.a_idx = 4'(i1);
						u.b_src = S_AR; u.b_idx = idx3(i2, j);
					end
					4'd6: begin
						u.kind = U_MAC; u.a_src = S_AE; u.a_idx = 4'(i2);
						u.b_src = S_AR; u.b_idx = idx3(i1, j);
					end
					4'd7: begin
						u.kind = U_MAC; u.a_src = S_BE; u.a_idx = 4'(j1);
						u.b_src = S_AR; u.b_idx = idx3(i, j2);
					end
					4'd8: begin
						u.kind = U_MAC; u.a_src = S_BE; u.a_idx = 4'(j2);
						u.b_src = S_AR; u.b_idx = idx3(i, j1);
					end
					4'd9: u.kind = U_SHACC;
					default: begin
						u.kind = U_CMP; u.last = 1'b1;
					end
				endcase
			end
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/obbot_mac.sv =====
`default_nettype none
module obbot_mac
	import obbot_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [OP_W-1:0]   a,
	input  wire logic signed [OP_W-1:0]   b,
	output logic signed [ACC_W-1:0]       acc
);

	logic signed [DIG_W:0]   da, db;
	logic signed [PP_W-1:0]  pp_s1;
	logic [2:0]              ppsh_s1;
	logic                    ppneg_s1;
	logic                    ppv_s1;
	logic signed [ACC_W-1:0] pp_ext, pp_sh, a_ext, a_sh, acc_q;

	// Low digits are unsigned, the top digit carries the sign.
	always_comb begin
		case (ctl.p)
			2'd0:    da = $signed({1'b0, a[DIG_W-1:0]});
			2'd1:    da = $signed({1'b0, a[2*DIG_W-1:DIG_W]});
			default: da = $signed({a[OP_W-1], a[OP_W-1:2*DIG_W]});
		endcase
		case (ctl.q)
			2'd0:    db = $signed({1'b0, b[DIG_W-1:0]});
			2'd1:    db = $signed({1'b0, b[2*DIG_W-1:DIG_W]});
			default: db = $signed({b[OP_W-1], b[OP_W-1:2*DIG_W]});
		endcase
	end

	always_ff @(posedge clk) begin
		pp_s1    <= da * db;
		ppsh_s1  <= 3'(ctl.p) + 3'(ctl.q);
		ppneg_s1 <= ctl.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppv_s1 <= 1'b0;
		end else begin
			ppv_s1 <= ctl.go && (ctl.kind == U_MAC);
		end
	end

	always_comb begin
		pp_ext = ACC_W'(pp_s1);
		case (ppsh_s1)
			3'd0:    pp_sh = pp_ext;
			3'd1:    pp_sh = pp_ext <<< DIG_W;
			3'd2:    pp_sh = pp_ext <<< (2 * DIG_W);
			3'd3:    pp_sh = pp_ext <<< (3 * DIG_W);
			default: pp_sh = pp_ext <<< (4 * DIG_W);
		endcase
		a_ext = ACC_W'(a);
		case (ctl.sh)
			2'd0:    a_sh = a_ext;
			2'd1:    a_sh = a_ext <<< FRAC_BITS;
			2'd2:    a_sh = a_ext <<< (2 * FRAC_BITS);
			default: a_sh = a_ext <<< (3 * FRAC_BITS);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ppv_s1) begin
			acc_q <= ppneg_s1 ? acc_q - pp_sh : acc_q + pp_sh;
		end else if (ctl.go) begin
			case (ctl.kind)
				U_CLR:   acc_q <= '0;
				U_ADD:   acc_q <= acc_q + a_sh;
				U_SHACC: acc_q <= acc_q <<< FRAC_BITS;
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== hdl/obb_overlap_test_unit.sv =====
// Oriented box overlap test by the separating axis theorem, Q16.16 operands.
// Input stream s_*: tuser carries cmd, box and slot; tdata carries value.
// A load item (cmd 0) writes one scalar of box A or B into the operand memory
// and gives no result. A test item (cmd 1) gives one result item on m_*:
// tdata bit 0 is 1 when no axis separates the boxes.
// Epsilon is written through cfg_* by the user only while the unit is idle;
// the unit does not enforce this. A test copies the 30 operands out of the
// memory, then runs a microprogram on one multiply-accumulate unit that takes
// each 72 by 72 bit product as 25 by 25 bit partial products of its 24-bit
// digits. A test ends early at the first separating axis.
// One test is in flight at a time; s_tready is low while it runs.
// A finished result waits in the output register while loads go on; if the
// receiver stalls, the next test waits for that register before finishing.
// Reset empties the output register, clears epsilon and marks every memory
// entry as zero through per-entry valid bits.
`default_nettype none
module obb_overlap_test_unit
	import obbot_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // [31:0] value
	input  wire logic [5:0]            s_tuser,   // [0] cmd, [1] box, [5:2] slot
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // [0] intersects, rest zero
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [EPS_W-1:0]      cfg_data   // epsilon
);

	state_t state_q, state_d;

	logic [EPS_W-1:0] eps_q;

	// Operand memory with one valid bit per entry, so reset reads as zero.
	logic [VALUE_WIDTH-1:0] mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   vld_q;
	logic [ADDR_W-1:0]      wr_addr, rd_addr, addr_s1;
	logic [VALUE_WIDTH-1:0] rd_data_s1;
	logic                   rd_vld_s1, fv_s1;
	logic [ADDR_W-1:0]      fcnt_q;

	logic                   accept, do_load, do_test;
	logic                   slot_b;
	logic [3:0]             slot_s1;
	logic [VALUE_WIDTH-1:0] word_s1;

	// Local copies of the operands and derived values.
	logic signed [VALUE_WIDTH-1:0] ac_q [3];
	logic signed [VALUE_WIDTH-1:0] bc_q [3];
	logic signed [VALUE_WIDTH-1:0] ae_q [3];
	logic signed [VALUE_WIDTH-1:0] be_q [3];
	logic signed [VALUE_WIDTH-1:0] au_q [9];
	logic signed [VALUE_WIDTH-1:0] bu_q [9];
	logic signed [RW-1:0]          t_q  [3];
	logic signed [RW-1:0]          r_q  [9];
	logic signed [RW-1:0]          ar_q [9];

	phase_t      ph_q;
	logic [1:0]  i_q, j_q;
	logic [3:0]  step_q;
	logic [1:0]  mp_q, mq_q;
	logic        drain_q;
	uop_t        u;
	logic        adv, sep, finish, res_d, res_q, out_free;

	mac_ctl_t                ctl;
	logic signed [OP_W-1:0]  op_a, op_b;
	logic signed [ACC_W-1:0] acc, acc_abs;
	logic signed [ACC_W-1:0] lhs_q;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign do_load   = accept && (s_tuser[0] == CMD_LOAD);
	assign do_test   = accept && (s_tuser[0] == CMD_TEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	// ---------------- operand memory ----------------
	assign wr_addr = s_tuser[1] ? ADDR_W'(s_tuser[5:2]) + ADDR_W'(NUM_SLOTS)
	                            : ADDR_W'(s_tuser[5:2]);
	assign rd_addr = fcnt_q;

	always_ff @(posedge clk) begin
		if (do_load && (s_tuser[5:2] != 4'(NUM_SLOTS))) begin
			mem_q[wr_addr] <= s_tdata[VALUE_WIDTH-1:0];
		end
		rd_data_s1 <= mem_q[rd_addr];
		addr_s1    <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			fv_s1     <= 1'b0;
		end else begin
			if (do_load && (s_tuser[5:2] != 4'(NUM_SLOTS))) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_s1 <= vld_q[rd_addr];
			fv_s1     <= (state_q == ST_FETCH) && (fcnt_q != ADDR_W'(MEM_DEPTH));
		end
	end

	// Spread the fetched words into the operand registers.
	assign slot_b  = addr_s1 >= ADDR_W'(NUM_SLOTS);
	assign slot_s1 = slot_b ? 4'(addr_s1 - ADDR_W'(NUM_SLOTS)) : 4'(addr_s1);
	assign word_s1 = rd_vld_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk) begin
		if (fv_s1) begin
			case (slot_s1) inside
				[4'd0:4'd2]: begin
					if (slot_b) bc_q[slot_s1[1:0]] <= word_s1;
					else        ac_q[slot_s1[1:0]] <= word_s1;
				end
				[4'd3:4'd5]: begin
					if (slot_b) be_q[2'(slot_s1 - 4'd3)] <= word_s1;
					else        ae_q[2'(slot_s1 - 4'd3)] <= word_s1;
				end
				default: begin
					if (slot_b) bu_q[slot_s1 - 4'd6] <= word_s1;
					else        au_q[slot_s1 - 4'd6] <= word_s1;
				end
			endcase
		end
	end

	// ---------------- operand select ----------------
	function automatic logic signed [OP_W-1:0] pick(input src_t s, input logic [3:0] x);
		logic signed [VALUE_WIDTH:0] dv;
		dv = {bc_q[x[1:0]][VALUE_WIDTH-1], bc_q[x[1:0]]}
		   - {ac_q[x[1:0]][VALUE_WIDTH-1], ac_q[x[1:0]]};
		case (s)
			S_AE:    return OP_W'(ae_q[x[1:0]]);
			S_BE:    return OP_W'(be_q[x[1:0]]);
			S_AU:    return OP_W'(au_q[x]);
			S_BU:    return OP_W'(bu_q[x]);
			S_V:     return OP_W'(dv);
			S_T:     return OP_W'(t_q[x[1:0]]);
			S_R:     return OP_W'(r_q[x]);
			default: return OP_W'(ar_q[x]);
		endcase
	endfunction

	assign u    = uop_at(ph_q, i_q, j_q, step_q);
	assign op_a = pick(u.a_src, u.a_idx);
	assign op_b = pick(u.b_src, u.b_idx);

	always_comb begin
		ctl      = mac_ctl_t'('0);
		ctl.kind = u.kind;
		ctl.neg  = u.neg;
		ctl.sh   = u.sh;
		ctl.p    = mp_q;
		ctl.q    = mq_q;
		adv      = 1'b0;
		if (state_q == ST_RUN) begin
			if (u.kind == U_MAC) begin
				ctl.go = !drain_q;
				adv    = drain_q;
			end else begin
				ctl.go = 1'b1;
				adv    = 1'b1;
			end
		end
	end

	obbot_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a      (op_a),
		.b      (op_b),
		.acc    (acc)
	);

	assign acc_abs = acc[ACC_W-1] ? -acc : acc;
	assign sep     = lhs_q > acc;

	// A run ends at a separating axis or after the last cross axis.
	always_comb begin
		finish = 1'b0;
		res_d  = 1'b1;
		if ((state_q == ST_RUN) && adv) begin
			if ((u.kind == U_CMP) && sep) begin
				finish = 1'b1;
				res_d  = 1'b0;
			end else if (u.last && (ph_q == PH_X) && (i_q == 2'd2) && (j_q == 2'd2)) begin
				finish = 1'b1;
			end
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q  <= '0;
			ph_q    <= PH_T;
			i_q     <= '0;
			j_q     <= '0;
			step_q  <= '0;
			mp_q    <= '0;
			mq_q    <= '0;
			drain_q <= 1'b0;
			res_q   <= 1'b0;
		end else begin
			if (do_test) begin
				fcnt_q <= '0;
				ph_q   <= PH_T;
				i_q    <= '0;
				j_q    <= '0;
				step_q <= '0;
			end else if ((state_q == ST_FETCH) && (fcnt_q != ADDR_W'(MEM_DEPTH))) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (finish) begin
				res_q <= res_d;
			end
			if ((state_q == ST_RUN) && (u.kind == U_MAC)) begin
				if (drain_q) begin
					drain_q <= 1'b0;
				end else if (mq_q == 2'd2) begin
					mq_q <= 2'd0;
					if (mp_q == 2'd2) begin
						mp_q    <= 2'd0;
						drain_q <= 1'b1;
					end else begin
						mp_q <= mp_q + 2'd1;
					end
				end else begin
					mq_q <= mq_q + 2'd1;
				end
			end
			if ((state_q == ST_RUN) && adv) begin
				if (u.last) begin
					step_q <= '0;
					if (((ph_q == PH_R) || (ph_q == PH_X)) && (j_q != 2'd2)) begin
						j_q <= j_q + 2'd1;
					end else begin
						j_q <= '0;
						if (i_q != 2'd2) begin
							i_q <= i_q + 2'd1;
						end else begin
							i_q <= '0;
							case (ph_q)
								PH_T:    ph_q <= PH_R;
								PH_R:    ph_q <= PH_A;
								PH_A:    ph_q <= PH_B;
								PH_B:    ph_q <= PH_X;
								default: ph_q <= PH_T;
							endcase
						end
					end
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// Stores of derived values; |R| gets epsilon at the product scale.
	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && adv) begin
			case (u.kind)
				U_STT: t_q[u.a_idx[1:0]] <= acc[RW-1:0];
				U_STR: begin
					r_q[u.a_idx]  <= acc[RW-1:0];
					ar_q[u.a_idx] <= acc_abs[RW-1:0] + (RW'(eps_q) << FRAC_BITS);
				end
				U_LHS: lhs_q <= acc_abs;
				default: ;
			endcase
		end
	end

	// ---------------- control state machine ----------------
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (do_test) state_d = ST_FETCH;
			ST_FETCH: if (fcnt_q == ADDR_W'(MEM_DEPTH)) state_d = ST_RUN;
			ST_RUN:   if (finish) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid <= 1'b1;
			m_tdata  <= {7'd0, res_q};
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/obbot_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module obbot_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [5:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// A stalled result stays offered.
	`ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// A stalled result keeps its value.
	`ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	// Only the flag bit of a result may be set.
	`ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0)
	// A test occupies the unit, so the input closes right after it.
	`ASSERT_NXT(a_test_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)

endmodule

bind obb_overlap_test_unit obbot_checker u_obbot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import obbot_pkg::*;

	// Signed 256-bit words are wide enough for every product and shifted sum
	// that the overlap test forms from 32-bit operands.
	typedef logic signed [255:0] wide_t;

	// One input item: the command, the box and slot it names, and the scalar.
	typedef struct packed {
		logic        cmd;
		logic        box;
		logic [3:0]  slot;
		logic [31:0] value;
	} box_item_t;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int ONE = 1 << FRAC_BITS;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;   // [31:0] value
	logic [5:0]           s_tuser;   // [0] cmd, [1] box, [5:2] slot
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [0] intersects
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [EPS_W-1:0]     cfg_data;

	obb_overlap_test_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Stimulus waiting to be offered, and the intersect flags still owed by the block.
	box_item_t pending_items[$];
	logic      owed_flags[$];

	// Our own copy of the operand memory and the tolerance register.
	logic signed [31:0] box_store[MEM_DEPTH];
	logic [EPS_W-1:0]   eps_shadow;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned errors;
	int unsigned tests_checked;
	int unsigned hits_seen;
	int unsigned cycle_count;
	logic        hold_req;
	logic        hold_started;
	int unsigned hold_left;

	// The clock runs from time zero; the period is 4 ns.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string what);
		$display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
		errors++;
	endtask

	function automatic wide_t mag(input wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// Separating axis test on the shadow operands. Everything is kept at an
	// exact common scale, so each comparison is a plain signed compare.
	function automatic logic predict_overlap();
		wide_t ac[3], ae[3], bc[3], be[3], au[3][3], bu[3][3];
		wide_t rot[3][3], arot[3][3], tr[3], dv[3];
		wide_t eps, rhs, lhs, ra, rb;
		int i, j, k, i1, i2, j1, j2;
		for (k = 0; k < 3; k++) begin
			ac[k] = wide_t'(box_store[k]);
			ae[k] = wide_t'(box_store[3 + k]);
			bc[k] = wide_t'(box_store[NUM_SLOTS + k]);
			be[k] = wide_t'(box_store[NUM_SLOTS + 3 + k]);
			for (i = 0; i < 3; i++) begin
				au[k][i] = wide_t'(box_store[6 + 3 * k + i]);
				bu[k][i] = wide_t'(box_store[NUM_SLOTS + 6 + 3 * k + i]);
			end
		end
		eps = wide_t'({1'b0, eps_shadow}) <<< FRAC_BITS;
		for (k = 0; k < 3; k++)
			dv[k] = bc[k] - ac[k];
		for (i = 0; i < 3; i++) begin
			tr[i] = dv[0] * au[i][0] + dv[1] * au[i][1] + dv[2] * au[i][2];
			for (j = 0; j < 3; j++) begin
				rot[i][j] = au[i][0] * bu[j][0] + au[i][1] * bu[j][1] + au[i][2] * bu[j][2];
				arot[i][j] = mag(rot[i][j]) + eps;
			end
		end
		// Axes of box A.
		for (i = 0; i < 3; i++) begin
			rhs = ae[i] <<< (2 * FRAC_BITS);
			for (k = 0; k < 3; k++)
				rhs = rhs + be[k] * arot[i][k];
			if ((mag(tr[i]) <<< FRAC_BITS) > rhs)
				return 1'b0;
		end
		// Axes of box B.
		for (j = 0; j < 3; j++) begin
			lhs = 0;
			ra = 0;
			for (k = 0; k < 3; k++) begin
				lhs = lhs + tr[k] * rot[k][j];
				ra = ra + ae[k] * arot[k][j];
			end
			ra = (ra <<< FRAC_BITS) + (be[j] <<< (3 * FRAC_BITS));
			if (mag(lhs) > ra)
				return 1'b0;
		end
		// The cross products of the edges of box A and box B.
		for (i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (j = 0; j < 3; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				lhs = tr[i2] * rot[i1][j] - tr[i1] * rot[i2][j];
				ra = ae[i1] * arot[i2][j] + ae[i2] * arot[i1][j];
				rb = be[j1] * arot[i][j2] + be[j2] * arot[i][j1];
				if (mag(lhs) > ((ra + rb) <<< FRAC_BITS))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Cycle count and the overall time limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Input driver. An item that is accepted at this edge goes into the shadow
	// model right here, in order, before the next one is put on the bus.
	always @(posedge clk or negedge arst_n) begin
		box_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_LOAD) begin
					if (s_tuser[5:2] < NUM_SLOTS)
						box_store[s_tuser[1] * NUM_SLOTS + s_tuser[5:2]] = s_tdata;
				end else begin
					owed_flags.insert(owed_flags.size(), predict_overlap());
				end
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.value;
					s_tuser  <= {nxt.slot, nxt.box, nxt.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// The long receiver hold-off gets its own counter, so the block fills its
	// output register and then has to stall the next test.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_started <= 1'b0;
			hold_left    <= 0;
		end else if (hold_req && !hold_started) begin
			hold_started <= 1'b1;
			hold_left    <= 6000;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor and receiver backpressure.
	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_flags.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0b", m_tdata[0]));
				end else begin
					want = owed_flags.pop_front();
					tests_checked++;
					if (m_tdata[0] !== want)
						report_mismatch($sformatf("intersects %0b, predicted %0b",
							m_tdata[0], want));
					if (want)
						hits_seen++;
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_item(input logic cmd, input logic box, input int slot,
			input logic [31:0] value);
		box_item_t it;
		it.cmd = cmd;
		it.box = box;
		it.slot = slot[3:0];
		it.value = value;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic load_box(input logic box, input int cx, input int cy, input int cz,
			input int ex, input int ey, input int ez);
		int k;
		push_item(CMD_LOAD, box, 0, cx);
		push_item(CMD_LOAD, box, 1, cy);
		push_item(CMD_LOAD, box, 2, cz);
		push_item(CMD_LOAD, box, 3, ex);
		push_item(CMD_LOAD, box, 4, ey);
		push_item(CMD_LOAD, box, 5, ez);
		for (k = 0; k < 9; k++)
			push_item(CMD_LOAD, box, 6 + k, (k % 4 == 0) ? ONE : 0);
	endtask

	// A whole box with plausible geometry: axes are a signed permutation of
	// the unit axes, sometimes nudged, so both outcomes turn up often.
	task automatic load_random_box(input logic box);
		int rot, k, c, comp;
		logic nudge;
		rot = $urandom_range(2);
		nudge = ($urandom_range(3) == 0);
		for (k = 0; k < 3; k++)
			push_item(CMD_LOAD, box, k, $urandom_range(6 * ONE) - 3 * ONE);
		for (k = 0; k < 3; k++)
			push_item(CMD_LOAD, box, 3 + k, ($urandom_range(15) == 0) ?
				-$urandom_range(ONE) : $urandom_range(2 * ONE, ONE / 4));
		for (k = 0; k < 3; k++)
			for (c = 0; c < 3; c++) begin
				comp = (c == (k + rot) % 3) ? (($urandom_range(1) != 0) ? ONE : -ONE) : 0;
				if (nudge)
					comp = comp + $urandom_range(ONE / 5) - ONE / 10;
				push_item(CMD_LOAD, box, 6 + 3 * k + c, comp);
			end
	endtask

	// Random traffic for one phase: mostly well-formed box loads followed by a
	// test, with some raw scalar tweaks and some pure noise.
	task automatic fill_phase(input int unsigned count);
		int unsigned start, n, k;
		start = pending_items.size();
		while (pending_items.size() - start < count) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					load_random_box(1'b0);
					load_random_box(1'b1);
				end
				5, 6: begin
					load_random_box(1'($urandom_range(1)));
				end
				7, 8: begin
					n = $urandom_range(4, 1);
					for (k = 0; k < n; k++)
						push_item(CMD_LOAD, 1'($urandom_range(1)), $urandom_range(15),
							$urandom());
				end
				default: begin
					n = $urandom_range(3, 1);
					for (k = 0; k < n; k++)
						push_item(CMD_LOAD, 1'($urandom_range(1)), $urandom_range(15),
							$urandom_range(4 * ONE) - 2 * ONE);
				end
			endcase
			push_item(CMD_TEST, 1'($urandom_range(1)), $urandom_range(15), $urandom());
		end
	endtask

	// Block until every offered item is taken and every result is back, then
	// leave room for the longest test before touching the register.
	task automatic drain_block();
		while (pending_items.size() != 0 || s_tvalid || owed_flags.size() != 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [EPS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		eps_shadow = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_req = 1'b0;
		errors = 0;
		tests_checked = 0;
		hits_seen = 0;
		cycle_count = 0;
		send_idle_pct = 17;
		recv_idle_pct = 72;
		eps_shadow = '0;
		for (k = 0; k < MEM_DEPTH; k++)
			box_store[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A test on a cleared memory comes first: every
		// operand is zero, so the boxes touch and the answer is intersecting.
		write_epsilon('0);
		push_item(CMD_TEST, 1'b1, 15, 32'hFFFF_FFFF);
		load_box(1'b0, 0, 0, 0, ONE, ONE, ONE);
		load_box(1'b1, 3 * ONE, 0, 0, ONE, ONE, ONE);
		push_item(CMD_TEST, 1'b0, 0, 0);            // far apart on x
		push_item(CMD_LOAD, 1'b1, 0, 2 * ONE);      // faces exactly touching
		push_item(CMD_TEST, 1'b0, 0, 0);
		push_item(CMD_LOAD, 1'b1, 15, 5 * ONE);     // slot fifteen is dropped
		push_item(CMD_TEST, 1'b1, 7, 32'h1234_5678);
		push_item(CMD_LOAD, 1'b0, 3, -ONE);         // negative half extent
		push_item(CMD_TEST, 1'b0, 0, 0);
		push_item(CMD_LOAD, 1'b0, 3, 32'h7FFF_FFFF);
		push_item(CMD_LOAD, 1'b1, 14, 32'h8000_0000);
		push_item(CMD_LOAD, 1'b1, 0, 32'h8000_0000);
		push_item(CMD_TEST, 1'b0, 0, 0);
		drain_block();

		// First phase: sender rarely idle, receiver mostly stalled.
		write_epsilon(EPS_W'($urandom_range(ONE)));
		fill_phase(460);
		drain_block();

		// Second phase at the largest tolerance, idling swapped, and one long
		// receiver hold-off while the sender keeps offering items.
		write_epsilon(EPS_W'(ONE));
		send_idle_pct = 72;
		recv_idle_pct = 17;
		hold_req = 1'b1;
		fill_phase(460);
		drain_block();

		// Last phase with no idling at all and a small nonzero tolerance.
		write_epsilon(EPS_W'($urandom_range(255, 1)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_phase(460);
		drain_block();

		$display("tb_top: %0d overlap tests checked, %0d intersecting, %0d disjoint",
			tests_checked, hits_seen, tests_checked - hits_seen);
		$display("tb_top: covered touching faces, ignored slot, extreme operands, epsilon 0..1.0");
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/obbot_pkg.sv
hdl/obbot_mac.sv
hdl/obb_overlap_test_unit.sv
hdl/obbot_checker.sv
bench/tb_top.sv
